// ----- hdl/kmct_pkg.sv -----
// Shared constants, codes and the Tokhura weight table of the codebook trainer.
// No dependencies; the interfaces, the top level, the checker and the testbench refer to it by scoped names.
`default_nettype none
package kmct_pkg;

	// Default geometry of the codebook and the vector store
	localparam int CODEBOOK_SIZE = 8;
	localparam int DIMENSION     = 12;
	localparam int MAX_VECTORS   = 4096;

	// Fixed field widths
	localparam int COEF_WIDTH   = 16;
	localparam int ACTION_WIDTH = 3;
	localparam int VIDX_WIDTH   = 12;
	localparam int CIDX_WIDTH   = 3;
	localparam int KIDX_WIDTH   = 4;
	localparam int STATUS_WIDTH = 3;
	localparam int DIST_WIDTH   = 42;
	localparam int ITER_WIDTH   = 10;
	localparam int CFG_WIDTH    = 42;
	localparam int CFG_IDX_WIDTH = 1;
	localparam int WEIGHT_WIDTH = 6;

	// Register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_ITERATIONS = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_THRESHOLD      = 1'd1;

	// Register reset values
	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET  = 10'd100;
	localparam logic [DIST_WIDTH-1:0] THRESHOLD_RESET = 42'd1;

	// Request actions
	localparam logic [ACTION_WIDTH-1:0] ACT_LOAD  = 3'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_SEED  = 3'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_RUN   = 3'd2;
	localparam logic [ACTION_WIDTH-1:0] ACT_READ  = 3'd3;
	localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR = 3'd4;

	// Result status codes
	localparam logic [STATUS_WIDTH-1:0] ST_READ_OK   = 3'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_CONVERGED = 3'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_ITER_LIM  = 3'd2;
	localparam logic [STATUS_WIDTH-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_WIDTH-1:0] ST_NO_DATA   = 3'd4;

	// Tokhura weights; positions past the twelfth reuse the last one
	function automatic logic [WEIGHT_WIDTH-1:0] tokhura_weight(input logic [7:0] pos);
		logic [WEIGHT_WIDTH-1:0] w;
		case (pos)
			8'd0:    w = 6'd1;
			8'd1:    w = 6'd3;
			8'd2:    w = 6'd7;
			8'd3:    w = 6'd13;
			8'd4:    w = 6'd19;
			8'd5:    w = 6'd22;
			8'd6:    w = 6'd25;
			8'd7:    w = 6'd33;
			8'd8:    w = 6'd42;
			8'd9:    w = 6'd50;
			8'd10:   w = 6'd56;
			default: w = 6'd61;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/kmct_if.sv -----
// Request and result channel interfaces of the codebook trainer.
// Depends on kmct_pkg for the field widths.
`default_nettype none
interface kmct_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [kmct_pkg::ACTION_WIDTH-1:0]     action;
	logic signed [kmct_pkg::COEF_WIDTH-1:0] coefficient;
	logic [kmct_pkg::VIDX_WIDTH-1:0]       vector_index;
	logic [kmct_pkg::CIDX_WIDTH-1:0]       centroid_index;
	logic [kmct_pkg::KIDX_WIDTH-1:0]       coefficient_index;

	modport source (output valid, action, coefficient, vector_index, centroid_index,
		coefficient_index, input ready);
	modport sink (input valid, action, coefficient, vector_index, centroid_index,
		coefficient_index, output ready);
endinterface

interface kmct_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [kmct_pkg::STATUS_WIDTH-1:0]      status;
	logic [kmct_pkg::DIST_WIDTH-1:0]        distortion;
	logic signed [kmct_pkg::COEF_WIDTH-1:0] coefficient_value;
	logic [kmct_pkg::ITER_WIDTH-1:0]        iterations_done;

	modport source (output valid, status, distortion, coefficient_value, iterations_done,
		input ready);
	modport sink (input valid, status, distortion, coefficient_value, iterations_done,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/kmct_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module kmct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/kmct_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; shared by the mean distortion and the centroid update.
`default_nettype none
module kmct_div #(
	parameter int DVD_WIDTH = 55,
	parameter int DVS_WIDTH = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DVD_WIDTH-1:0] dividend,
	input  wire logic [DVS_WIDTH-1:0] divisor,
	output logic                      done,
	output logic      [DVD_WIDTH-1:0] quotient
);
	localparam int CW = $clog2(DVD_WIDTH + 1);

	logic [DVD_WIDTH-1:0] dvd_q;
	logic [DVS_WIDTH-1:0] dvs_q;
	logic [DVS_WIDTH-1:0] rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [DVS_WIDTH:0]   trial;
	logic                 fits;

	// trial subtraction of the next bit
	assign trial = {rem_q, dvd_q[DVD_WIDTH-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DVD_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_WIDTH-2:0], fits};
			rem_q <= fits ? DVS_WIDTH'(trial - {1'b0, dvs_q}) : trial[DVS_WIDTH-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

// ----- hdl/kmeans_codebook_trainer.sv -----
// K-means codebook trainer top level: sequencer, stores and result register.
// Depends on kmct_pkg, kmct_if, kmct_ram and kmct_div.
//
// Load, clear and unknown requests are taken without leaving the idle state, so
// coefficients stream in back to back. A seed copies a vector into a centroid slot
// coefficient by coefficient, and a read fetches one centroid coefficient. A run holds
// the request channel for its whole duration: each pass clears the sums, then takes
// each vector through the single square-and-weight datapath, then computes the mean
// distortion and, if the pass goes on, the centroid update, both in the one shared
// radix-2 divider. A result waits in an output register; the block takes the next
// request as soon as that register is free.
`default_nettype none
module kmeans_codebook_trainer #(
	parameter int CODEBOOK_SIZE = kmct_pkg::CODEBOOK_SIZE,
	parameter int DIMENSION     = kmct_pkg::DIMENSION,
	parameter int MAX_VECTORS   = kmct_pkg::MAX_VECTORS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [kmct_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  wire logic [kmct_pkg::CFG_WIDTH-1:0]      cfg_wdata,
	kmct_in_if.sink                                  items,
	kmct_out_if.source                               results
);
	localparam int CW    = kmct_pkg::COEF_WIDTH;
	localparam int KD    = CODEBOOK_SIZE * DIMENSION;
	localparam int VD    = MAX_VECTORS * DIMENSION;
	localparam int VAW   = $clog2(VD);
	localparam int WPW   = $clog2(VD + 1);
	localparam int CAW   = $clog2(KD);
	localparam int CNTW  = $clog2(MAX_VECTORS + 1);
	localparam int KW    = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
	localparam int JW    = $clog2(CODEBOOK_SIZE);
	localparam int SQW   = 2 * CW;
	localparam int WSQW  = SQW + kmct_pkg::WEIGHT_WIDTH;
	localparam int DISTW = WSQW + $clog2(DIMENSION);
	localparam int TOTW  = DISTW + CNTW;
	localparam int SUMW  = CW + $clog2(MAX_VECTORS);
	localparam int DW    = kmct_pkg::DIST_WIDTH;
	localparam int IW    = kmct_pkg::ITER_WIDTH;

	typedef enum logic [20:0] {
		S_IDLE    = 21'h000001,
		S_SEED_RD = 21'h000002,
		S_SEED_WR = 21'h000004,
		S_READ_RD = 21'h000008,
		S_READ_WT = 21'h000010,
		S_CLR     = 21'h000020,
		S_D_RD    = 21'h000040,
		S_D_SQ    = 21'h000080,
		S_D_WT    = 21'h000100,
		S_D_ACC   = 21'h000200,
		S_D_CMP   = 21'h000400,
		S_A_CNT   = 21'h000800,
		S_S_RD    = 21'h001000,
		S_S_WR    = 21'h002000,
		S_M_GO    = 21'h004000,
		S_M_WAIT  = 21'h008000,
		S_U_CHK   = 21'h010000,
		S_U_RD    = 21'h020000,
		S_U_DIV   = 21'h040000,
		S_U_WAIT  = 21'h080000,
		S_FIN     = 21'h100000
	} state_t;

	state_t state_q;

	// configuration and persistent state
	logic [IW-1:0]   max_it_q;
	logic [DW-1:0]   thr_q;
	logic [DW:0]     prev_q;
	logic [DW-1:0]   last_q;
	logic [WPW-1:0]  wptr_q;
	logic [CNTW-1:0] vcount_q;
	logic [KW-1:0]   lpos_q;

	// sequencer counters and datapath registers
	logic [KW-1:0]   k_q;
	logic [JW-1:0]   j_q;
	logic [JW-1:0]   bestj_q;
	logic [CNTW-1:0] i_q;
	logic [IW-1:0]   m_q;
	logic [VAW-1:0]  vbase_q;
	logic [CAW-1:0]  cbase_q;
	logic [CAW-1:0]  bbase_q;
	logic [CAW-1:0]  clr_q;
	logic [SQW-1:0]  sq_q;
	logic [WSQW-1:0] wsq_q;
	logic [DISTW-1:0] dist_q;
	logic [DISTW-1:0] best_q;
	logic [TOTW-1:0] total_q;
	logic [CNTW-1:0] counts_q [CODEBOOK_SIZE];
	logic            neg_q;
	logic            rd_ok_q;

	// pending and delivered result
	logic [kmct_pkg::STATUS_WIDTH-1:0] res_status_q;
	logic signed [CW-1:0]              res_coef_q;
	logic [IW-1:0]                     res_iters_q;
	logic                              out_valid_q;
	logic [kmct_pkg::STATUS_WIDTH-1:0] out_status_q;
	logic [DW-1:0]                     out_dist_q;
	logic signed [CW-1:0]              out_coef_q;
	logic [IW-1:0]                     out_iters_q;

	// memory ports
	logic            v_we;
	logic [VAW-1:0]  v_raddr;
	logic [CW-1:0]   v_rdata;
	logic            c_we;
	logic [CAW-1:0]  c_addr;
	logic [CW-1:0]   c_wdata;
	logic [CW-1:0]   c_rdata;
	logic            s_we;
	logic [CAW-1:0]  s_waddr;
	logic [CAW-1:0]  s_raddr;
	logic [SUMW-1:0] s_wdata;
	logic [SUMW-1:0] s_rdata;

	// divider
	logic            div_start;
	logic [TOTW-1:0] div_dividend;
	logic [CNTW-1:0] div_divisor;
	logic            div_done;
	logic [TOTW-1:0] div_quo;

	logic            accept;
	logic            out_free;
	logic            k_last;
	logic            j_last;
	logic [JW-1:0]   cnt_idx;
	logic [CNTW-1:0] cnt_sel;
	logic signed [CW:0] diff;
	logic [CW-1:0]   adiff;
	logic signed [SUMW-1:0] sum_new;
	logic [SUMW-1:0] sum_mag;
	logic [CW:0]     quo_c;
	logic [DW:0]     mean43;
	logic            conv;

	assign accept   = items.valid && items.ready;
	assign out_free = !out_valid_q || results.ready;
	assign k_last   = k_q == KW'(DIMENSION - 1);
	assign j_last   = j_q == JW'(CODEBOOK_SIZE - 1);

	// one count read port: the update walks j, the assignment uses the winner
	assign cnt_idx = (state_q == S_U_CHK || state_q == S_U_DIV) ? j_q : bestj_q;
	assign cnt_sel = counts_q[cnt_idx];

	// distance datapath pieces
	assign diff  = (CW+1)'(signed'(c_rdata)) - (CW+1)'(signed'(v_rdata));
	assign adiff = diff[CW] ? CW'(-diff) : diff[CW-1:0];
	assign sum_new = signed'(s_rdata) + SUMW'(signed'(v_rdata));
	assign sum_mag = s_rdata[SUMW-1] ? SUMW'(-signed'(s_rdata)) : s_rdata;
	assign quo_c   = div_quo[CW:0];

	// convergence test on the new mean
	assign mean43 = {1'b0, div_quo[DW-1:0]};
	assign conv   = (mean43 >= prev_q) || ((prev_q - mean43) <= {1'b0, thr_q});

	// memory port steering
	assign v_we    = accept && items.action == kmct_pkg::ACT_LOAD
		&& vcount_q != CNTW'(MAX_VECTORS);
	assign v_raddr = vbase_q + VAW'(k_q);
	assign c_addr  = cbase_q + CAW'(k_q);
	assign c_we    = (state_q == S_SEED_WR) || (state_q == S_U_WAIT && div_done);
	assign c_wdata = (state_q == S_SEED_WR) ? v_rdata
		: (neg_q ? CW'(-quo_c) : quo_c[CW-1:0]);
	assign s_we    = (state_q == S_CLR) || (state_q == S_S_WR);
	assign s_waddr = (state_q == S_CLR) ? clr_q : bbase_q + CAW'(k_q);
	assign s_wdata = (state_q == S_CLR) ? '0 : sum_new;
	assign s_raddr = (state_q == S_U_RD) ? c_addr : bbase_q + CAW'(k_q);

	// divider operands
	assign div_start    = (state_q == S_M_GO) || (state_q == S_U_DIV);
	assign div_dividend = (state_q == S_M_GO) ? total_q : TOTW'(sum_mag);
	assign div_divisor  = (state_q == S_M_GO) ? vcount_q : cnt_sel;

	kmct_ram #(.WIDTH(CW), .DEPTH(VD)) u_vec_ram (
		.clk(clk), .we(v_we), .waddr(wptr_q[VAW-1:0]), .wdata(items.coefficient),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	kmct_ram #(.WIDTH(CW), .DEPTH(KD)) u_cent_ram (
		.clk(clk), .we(c_we), .waddr(c_addr), .wdata(c_wdata),
		.raddr(c_addr), .rdata(c_rdata)
	);

	kmct_ram #(.WIDTH(SUMW), .DEPTH(KD)) u_sum_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	kmct_div #(.DVD_WIDTH(TOTW), .DVS_WIDTH(CNTW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_it_q <= kmct_pkg::MAX_ITER_RESET;
			thr_q    <= kmct_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmct_pkg::REG_MAX_ITERATIONS: max_it_q <= cfg_wdata[IW-1:0];
				kmct_pkg::REG_THRESHOLD:      thr_q    <= cfg_wdata[DW-1:0];
				default: ;
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wptr_q       <= '0;
			vcount_q     <= '0;
			lpos_q       <= '0;
			last_q       <= '0;
			prev_q       <= '1;
			k_q          <= '0;
			j_q          <= '0;
			bestj_q      <= '0;
			i_q          <= '0;
			m_q          <= '0;
			vbase_q      <= '0;
			cbase_q      <= '0;
			bbase_q      <= '0;
			clr_q        <= '0;
			sq_q         <= '0;
			wsq_q        <= '0;
			dist_q       <= '0;
			best_q       <= '0;
			total_q      <= '0;
			neg_q        <= 1'b0;
			rd_ok_q      <= 1'b0;
			res_status_q <= kmct_pkg::ST_READ_OK;
			res_coef_q   <= '0;
			res_iters_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q <= '0;
						case (items.action)
							kmct_pkg::ACT_LOAD: begin
								if (vcount_q != CNTW'(MAX_VECTORS)) begin
									wptr_q <= wptr_q + 1'b1;
									if (lpos_q == KW'(DIMENSION - 1)) begin
										lpos_q   <= '0;
										vcount_q <= vcount_q + 1'b1;
									end else begin
										lpos_q <= lpos_q + 1'b1;
									end
								end
							end
							kmct_pkg::ACT_SEED: begin
								vbase_q <= VAW'(32'(items.vector_index) * DIMENSION);
								cbase_q <= CAW'(32'(items.centroid_index) * DIMENSION);
								if (32'(items.vector_index) < 32'(vcount_q)
									&& 32'(items.centroid_index) < CODEBOOK_SIZE) begin
									state_q <= S_SEED_RD;
								end
							end
							kmct_pkg::ACT_RUN: begin
								res_coef_q <= '0;
								if (vcount_q == '0) begin
									res_status_q <= kmct_pkg::ST_NO_DATA;
									res_iters_q  <= '0;
									state_q      <= S_FIN;
								end else begin
									prev_q <= '1;
									if (max_it_q == '0) begin
										res_status_q <= kmct_pkg::ST_ITER_LIM;
										res_iters_q  <= '0;
										state_q      <= S_FIN;
									end else begin
										m_q     <= '0;
										clr_q   <= '0;
										state_q <= S_CLR;
									end
								end
							end
							kmct_pkg::ACT_READ: begin
								rd_ok_q <= 32'(items.centroid_index) < CODEBOOK_SIZE
									&& 32'(items.coefficient_index) < DIMENSION;
								cbase_q <= CAW'(32'(items.centroid_index) * DIMENSION
									+ 32'(items.coefficient_index));
								state_q <= S_READ_RD;
							end
							kmct_pkg::ACT_CLEAR: begin
								wptr_q   <= '0;
								vcount_q <= '0;
								lpos_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				// seed: copy one vector into a centroid slot
				S_SEED_RD: state_q <= S_SEED_WR;
				S_SEED_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= k_last ? S_IDLE : S_SEED_RD;
				end
				// read one centroid coefficient
				S_READ_RD: state_q <= S_READ_WT;
				S_READ_WT: begin
					res_status_q <= kmct_pkg::ST_READ_OK;
					res_coef_q   <= rd_ok_q ? signed'(c_rdata) : '0;
					res_iters_q  <= '0;
					state_q      <= S_FIN;
				end
				// pass start: sweep the sums, reset the walk
				S_CLR: begin
					clr_q   <= clr_q + 1'b1;
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
					vbase_q <= '0;
					cbase_q <= '0;
					dist_q  <= '0;
					total_q <= '0;
					if (clr_q == CAW'(KD - 1)) begin
						state_q <= S_D_RD;
					end
				end
				// weighted distance, one coefficient at a time
				S_D_RD: state_q <= S_D_SQ;
				S_D_SQ: begin
					sq_q    <= SQW'(adiff) * SQW'(adiff);
					state_q <= S_D_WT;
				end
				S_D_WT: begin
					wsq_q   <= WSQW'(kmct_pkg::tokhura_weight(8'(k_q))) * WSQW'(sq_q);
					state_q <= S_D_ACC;
				end
				S_D_ACC: begin
					dist_q  <= dist_q + DISTW'(wsq_q);
					k_q     <= k_q + 1'b1;
					state_q <= k_last ? S_D_CMP : S_D_RD;
				end
				// first minimum wins
				S_D_CMP: begin
					if (j_q == '0 || dist_q < best_q) begin
						best_q  <= dist_q;
						bestj_q <= j_q;
						bbase_q <= cbase_q;
					end
					dist_q <= '0;
					k_q    <= '0;
					if (j_last) begin
						state_q <= S_A_CNT;
					end else begin
						j_q     <= j_q + 1'b1;
						cbase_q <= cbase_q + CAW'(DIMENSION);
						state_q <= S_D_RD;
					end
				end
				S_A_CNT: begin
					total_q <= total_q + TOTW'(best_q);
					state_q <= S_S_RD;
				end
				// accumulate the vector into its cluster sums
				S_S_RD: state_q <= S_S_WR;
				S_S_WR: begin
					k_q <= k_q + 1'b1;
					if (k_last) begin
						k_q <= '0;
						if (i_q + 1'b1 == vcount_q) begin
							state_q <= S_M_GO;
						end else begin
							i_q     <= i_q + 1'b1;
							vbase_q <= vbase_q + VAW'(DIMENSION);
							j_q     <= '0;
							cbase_q <= '0;
							state_q <= S_D_RD;
						end
					end else begin
						state_q <= S_S_RD;
					end
				end
				// mean distortion and convergence
				S_M_GO: state_q <= S_M_WAIT;
				S_M_WAIT: begin
					if (div_done) begin
						last_q <= div_quo[DW-1:0];
						if (conv) begin
							res_status_q <= kmct_pkg::ST_CONVERGED;
							res_iters_q  <= m_q + 1'b1;
							state_q      <= S_FIN;
						end else begin
							prev_q  <= mean43;
							j_q     <= '0;
							cbase_q <= '0;
							k_q     <= '0;
							state_q <= S_U_CHK;
						end
					end
				end
				// centroid update, one divide per coefficient
				S_U_CHK: begin
					if (cnt_sel == '0) begin
						res_status_q <= kmct_pkg::ST_EMPTY;
						res_iters_q  <= m_q + 1'b1;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_U_RD;
					end
				end
				S_U_RD: state_q <= S_U_DIV;
				S_U_DIV: begin
					neg_q   <= s_rdata[SUMW-1];
					state_q <= S_U_WAIT;
				end
				S_U_WAIT: begin
					if (div_done) begin
						k_q <= k_q + 1'b1;
						if (!k_last) begin
							state_q <= S_U_RD;
						end else begin
							k_q <= '0;
							if (!j_last) begin
								j_q     <= j_q + 1'b1;
								cbase_q <= cbase_q + CAW'(DIMENSION);
								state_q <= S_U_CHK;
							end else if (m_q + 1'b1 == max_it_q) begin
								res_status_q <= kmct_pkg::ST_ITER_LIM;
								res_iters_q  <= max_it_q;
								state_q      <= S_FIN;
							end else begin
								m_q     <= m_q + 1'b1;
								clr_q   <= '0;
								state_q <= S_CLR;
							end
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// cluster member counts, cleared at each pass start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CODEBOOK_SIZE; c++) begin
				counts_q[c] <= '0;
			end
		end else if (state_q == S_CLR) begin
			for (int c = 0; c < CODEBOOK_SIZE; c++) begin
				counts_q[c] <= '0;
			end
		end else if (state_q == S_A_CNT) begin
			counts_q[bestj_q] <= cnt_sel + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_dist_q   <= last_q;
			out_coef_q   <= res_coef_q;
			out_iters_q  <= res_iters_q;
		end
	end

	assign items.ready               = state_q == S_IDLE;
	assign results.valid             = out_valid_q;
	assign results.status            = out_status_q;
	assign results.distortion        = out_dist_q;
	assign results.coefficient_value = out_coef_q;
	assign results.iterations_done   = out_iters_q;
endmodule
`default_nettype wire

// ----- hdl/kmct_checker.sv -----
// Port-level checks of the codebook trainer, bound to the top level.
// Depends on kmct_pkg and kmeans_codebook_trainer.
`default_nettype none
module kmct_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic [kmct_pkg::ACTION_WIDTH-1:0]   in_action,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [kmct_pkg::STATUS_WIDTH-1:0]   out_status,
	input wire logic [kmct_pkg::COEF_WIDTH-1:0]     out_coef,
	input wire logic [kmct_pkg::ITER_WIDTH-1:0]     out_iters
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_coef))
		else $error("stalled result changed");

	// ready is low in the cycle after a run or read request is taken
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_action == kmct_pkg::ACT_RUN
		|| in_action == kmct_pkg::ACT_READ) |=> !in_ready)
		else $error("ready right after run or read request");

	// read results carry no pass count
	a_read_iters: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == kmct_pkg::ST_READ_OK |-> out_iters == '0)
		else $error("read result with pass count");

	// run results carry no coefficient
	a_run_coef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != kmct_pkg::ST_READ_OK |-> out_coef == '0)
		else $error("run result with coefficient");
endmodule

bind kmeans_codebook_trainer kmct_checker u_kmct_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(items.valid), .in_ready(items.ready), .in_action(items.action),
	.out_valid(results.valid), .out_ready(results.ready), .out_status(results.status),
	.out_coef(results.coefficient_value), .out_iters(results.iterations_done)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench of the k-means codebook trainer: directed and random requests,
// with a request-level predictor of the codebook, the vector store and the run results.
// Depends on kmct_pkg, kmct_if and the kmeans_codebook_trainer RTL.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCENT = kmct_pkg::CODEBOOK_SIZE;
	localparam int NDIM  = kmct_pkg::DIMENSION;
	localparam int NVEC  = kmct_pkg::MAX_VECTORS;
	localparam int ACTW  = kmct_pkg::ACTION_WIDTH;
	localparam int COEFW = kmct_pkg::COEF_WIDTH;
	localparam int DISTW = kmct_pkg::DIST_WIDTH;
	localparam int ITERW = kmct_pkg::ITER_WIDTH;
	localparam int STW   = kmct_pkg::STATUS_WIDTH;
	localparam int IDXW  = kmct_pkg::CFG_IDX_WIDTH;
	localparam longint unsigned DIST_MASK = (64'd1 << DISTW) - 1;
	localparam longint unsigned PREV_INIT = (64'd1 << (DISTW + 1)) - 1;

	typedef struct packed {
		logic [ACTW-1:0]                        action;
		logic signed [COEFW-1:0]                coef;
		logic [kmct_pkg::VIDX_WIDTH-1:0]        vidx;
		logic [kmct_pkg::CIDX_WIDTH-1:0]        cidx;
		logic [kmct_pkg::KIDX_WIDTH-1:0]        kidx;
	} request_t;

	typedef struct packed {
		logic [STW-1:0]          status;
		logic [DISTW-1:0]        distortion;
		logic signed [COEFW-1:0] coef_value;
		logic [ITERW-1:0]        iterations;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDXW-1:0] cfg_index;
	logic [kmct_pkg::CFG_WIDTH-1:0] cfg_wdata;

	kmct_in_if  req_ch ();
	kmct_out_if res_ch ();

	kmeans_codebook_trainer dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .items(req_ch), .results(res_ch)
	);

	// Predictor state: codebook, vector store and registers
	longint vec_mem [NVEC*NDIM];
	longint codebook [NCENT*NDIM];
	int unsigned stored_vectors;
	int unsigned fill_pos;
	longint unsigned last_dist;
	longint unsigned iter_limit;
	longint unsigned conv_threshold;
	outcome_t awaited_results[$];

	int mismatches;
	int burst_left;
	bit valid_high;
	int hold_request;
	int random_items;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic request_t mk(logic [ACTW-1:0] a, logic [15:0] c = 0,
			logic [11:0] v = 0, logic [2:0] ci = 0, logic [3:0] ki = 0);
		request_t r;
		r.action = a; r.coef = c; r.vidx = v; r.cidx = ci; r.kidx = ki;
		return r;
	endfunction

	function automatic longint unsigned weighted_dist(int c, int v);
		longint unsigned sum;
		longint d;
		sum = 0;
		for (int k = 0; k < NDIM; k++) begin
			d = codebook[c*NDIM+k] - vec_mem[v*NDIM+k];
			if (d < 0) d = -d;
			sum += kmct_pkg::tokhura_weight(8'(k)) * longint'(d * d);
		end
		return sum;
	endfunction

	function automatic void expect_outcome(logic [STW-1:0] st, longint unsigned dist_val,
			longint coef, longint unsigned iters);
		outcome_t o;
		o.status = st; o.distortion = dist_val[DISTW-1:0];
		o.coef_value = coef[COEFW-1:0]; o.iterations = iters[ITERW-1:0];
		awaited_results = {awaited_results, o};
	endfunction

	// K-means run: no passes without data, else passes until convergence, the limit or an empty cluster
	function automatic void train_codebook();
		longint sums [NCENT*NDIM];
		int members [NCENT];
		longint unsigned prev, total, mean, best_d, d;
		int best;
		if (stored_vectors == 0) begin
			expect_outcome(kmct_pkg::ST_NO_DATA, last_dist, 0, 0);
			return;
		end
		prev = PREV_INIT;
		for (longint unsigned m = 0; m < iter_limit; m++) begin
			foreach (sums[i]) sums[i] = 0;
			foreach (members[i]) members[i] = 0;
			total = 0;
			for (int i = 0; i < stored_vectors; i++) begin
				best = 0;
				best_d = weighted_dist(0, i);
				for (int j = 1; j < NCENT; j++) begin
					d = weighted_dist(j, i);
					if (d < best_d) begin
						best_d = d;
						best = j;
					end
				end
				total += best_d;
				members[best]++;
				for (int k = 0; k < NDIM; k++) sums[best*NDIM+k] += vec_mem[i*NDIM+k];
			end
			mean = (total / stored_vectors) & DIST_MASK;
			last_dist = mean;
			if (mean >= prev || prev - mean <= conv_threshold) begin
				expect_outcome(kmct_pkg::ST_CONVERGED, last_dist, 0, m + 1);
				return;
			end
			prev = mean;
			for (int j = 0; j < NCENT; j++) begin
				if (members[j] == 0) begin
					expect_outcome(kmct_pkg::ST_EMPTY, last_dist, 0, m + 1);
					return;
				end
				for (int k = 0; k < NDIM; k++)
					codebook[j*NDIM+k] = sums[j*NDIM+k] / longint'(members[j]);
			end
		end
		expect_outcome(kmct_pkg::ST_ITER_LIM, last_dist, 0, iter_limit);
	endfunction

	function automatic void predict_request(request_t r);
		case (r.action)
			kmct_pkg::ACT_LOAD: begin
				if (stored_vectors < NVEC) begin
					vec_mem[stored_vectors*NDIM+fill_pos] = longint'(r.coef);
					fill_pos++;
					if (fill_pos >= NDIM) begin
						fill_pos = 0;
						stored_vectors++;
					end
				end
			end
			kmct_pkg::ACT_SEED: begin
				if (r.vidx < stored_vectors && r.cidx < NCENT)
					for (int k = 0; k < NDIM; k++)
						codebook[r.cidx*NDIM+k] = vec_mem[r.vidx*NDIM+k];
			end
			kmct_pkg::ACT_RUN: train_codebook();
			kmct_pkg::ACT_READ: begin
				if (r.cidx < NCENT && r.kidx < NDIM)
					expect_outcome(kmct_pkg::ST_READ_OK, last_dist,
						codebook[r.cidx*NDIM+r.kidx], 0);
				else
					expect_outcome(kmct_pkg::ST_READ_OK, last_dist, 0, 0);
			end
			kmct_pkg::ACT_CLEAR: begin
				stored_vectors = 0;
				fill_pos = 0;
			end
			default: ;
		endcase
	endfunction

	// One request: offer it, wait for acceptance, then maybe open a gap
	task automatic send_request(request_t r);
		req_ch.valid <= 1'b1;
		req_ch.action <= r.action;
		req_ch.coefficient <= r.coef;
		req_ch.vector_index <= r.vidx;
		req_ch.centroid_index <= r.cidx;
		req_ch.coefficient_index <= r.kidx;
		valid_high = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		predict_request(r);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			valid_high = 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 24);
		end else begin
			burst_left--;
		end
	endtask

	// Wait until every result is in and the block has finished any seed
	task automatic wait_idle();
		if (valid_high) begin
			req_ch.valid <= 1'b0;
			valid_high = 1'b0;
		end
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDXW-1:0] idx, longint unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[kmct_pkg::CFG_WIDTH-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == kmct_pkg::REG_MAX_ITERATIONS) iter_limit = value & 64'h3FF;
		else conv_threshold = value & DIST_MASK;
	endtask

	task automatic load_vector(logic [15:0] base, bit random_fill);
		for (int k = 0; k < NDIM; k++)
			send_request(mk(kmct_pkg::ACT_LOAD, random_fill ? 16'($urandom) : base));
	endtask

	// Receiver: stall pattern that changes at random, plus long hold-offs
	initial begin
		int hold_left;
		int mode;
		hold_left = 0;
		mode = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= $urandom_range(0, 1);
					default: res_ch.ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d distortion %0d", res_ch.status,
						res_ch.distortion);
			end else begin
				exp_o = awaited_results.pop_front();
				if (res_ch.status !== exp_o.status || res_ch.distortion !== exp_o.distortion
						|| res_ch.coefficient_value !== exp_o.coef_value
						|| res_ch.iterations_done !== exp_o.iterations) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected st %0d dist %0d coef %0d",
							" iter %0d, got st %0d dist %0d coef %0d iter %0d"},
							exp_o.status, exp_o.distortion, exp_o.coef_value, exp_o.iterations,
							res_ch.status, res_ch.distortion, res_ch.coefficient_value,
							res_ch.iterations_done);
				end
			end
		end
	end

	// Run with nothing loaded, unknown actions, a seed into an empty store and a clear
	task automatic test_no_data();
		send_request(mk(kmct_pkg::ACT_RUN));
		for (int a = 5; a < 8; a++) send_request(mk(3'(a)));
		send_request(mk(kmct_pkg::ACT_SEED, 0, 0, 3));
		send_request(mk(kmct_pkg::ACT_CLEAR));
	endtask

	// Coefficient extremes, partial vector, out-of-range seeds and reads
	task automatic test_directed();
		load_vector(16'h8000, 0);
		load_vector(16'h7FFF, 0);
		load_vector(16'h0000, 0);
		load_vector(16'hFFFF, 0);
		for (int v = 4; v < 9; v++) load_vector(0, 1);
		for (int k = 0; k < 5; k++) send_request(mk(kmct_pkg::ACT_LOAD, 16'h5555));
		for (int c = 0; c < NCENT; c++)
			send_request(mk(kmct_pkg::ACT_SEED, 0, 12'(c), 3'(c)));
		send_request(mk(kmct_pkg::ACT_SEED, 0, 12'd9, 3'd0));
		send_request(mk(kmct_pkg::ACT_SEED, 0, 12'hFFF, 3'd7));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd7, 4'd11));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd0, 4'd0));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd3, 4'd12));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd5, 4'd15));
		send_request(mk(kmct_pkg::ACT_RUN));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd1, 4'd4));
	endtask

	// Register extremes: zero and full iteration limit, zero and full threshold
	task automatic test_register_extremes();
		wait_idle();
		write_reg(kmct_pkg::REG_MAX_ITERATIONS, 0);
		send_request(mk(kmct_pkg::ACT_RUN));
		wait_idle();
		write_reg(kmct_pkg::REG_MAX_ITERATIONS, 1023);
		write_reg(kmct_pkg::REG_THRESHOLD, 0);
		send_request(mk(kmct_pkg::ACT_RUN));
		wait_idle();
		write_reg(kmct_pkg::REG_THRESHOLD, DIST_MASK);
		send_request(mk(kmct_pkg::ACT_RUN));
		wait_idle();
		write_reg(kmct_pkg::REG_MAX_ITERATIONS, 1);
		write_reg(kmct_pkg::REG_THRESHOLD, 1);
		send_request(mk(kmct_pkg::ACT_RUN));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd2, 4'd6));
	endtask

	// Two slots seeded from one vector leave a cluster empty
	task automatic test_empty_cluster();
		wait_idle();
		write_reg(kmct_pkg::REG_MAX_ITERATIONS, 8);
		send_request(mk(kmct_pkg::ACT_CLEAR));
		for (int v = 0; v < 10; v++) load_vector(0, 1);
		send_request(mk(kmct_pkg::ACT_SEED, 0, 12'd4, 3'd0));
		for (int c = 1; c < NCENT; c++)
			send_request(mk(kmct_pkg::ACT_SEED, 0, 12'(c + 3), 3'(c)));
		send_request(mk(kmct_pkg::ACT_RUN));
	endtask

	// Receiver holds off while reads pile up behind the result register
	task automatic test_backpressure();
		wait_idle();
		hold_request = 300;
		for (int i = 0; i < 16; i++)
			send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'($urandom),
				4'($urandom_range(0, 15))));
	endtask

	// Random training sessions with noise between the well-formed requests
	task automatic test_random_sessions();
		int nvec;
		int nreq;
		while (random_items < 480) begin
			wait_idle();
			write_reg(kmct_pkg::REG_MAX_ITERATIONS,
				$urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 5));
			write_reg(kmct_pkg::REG_THRESHOLD, $urandom_range(0, 3) == 0 ?
				{$urandom, $urandom} : $urandom_range(0, 2000));
			send_request(mk(kmct_pkg::ACT_CLEAR));
			nvec = $urandom_range(8, 20);
			for (int v = 0; v < nvec; v++) load_vector(0, 1);
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 11))
					send_request(mk(kmct_pkg::ACT_LOAD, 16'($urandom)));
			for (int c = 0; c < NCENT; c++)
				send_request(mk(kmct_pkg::ACT_SEED, 0, 12'($urandom_range(0, nvec - 1)),
					3'(c)));
			nreq = nvec * NDIM + NCENT + 1;
			repeat ($urandom_range(2, 12)) begin
				case ($urandom_range(0, 3))
					0: send_request(mk(3'($urandom_range(5, 7)), 16'($urandom)));
					1: send_request(mk(kmct_pkg::ACT_SEED, 0, 12'($urandom), 3'($urandom)));
					default: send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'($urandom),
						4'($urandom_range(0, 15))));
				endcase
				nreq++;
			end
			send_request(mk(kmct_pkg::ACT_RUN));
			repeat ($urandom_range(1, 6)) begin
				send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'($urandom),
					4'($urandom_range(0, 15))));
				nreq++;
			end
			random_items += nreq;
		end
	endtask

	// Seed from the last whole vector, read it back, then clear and run on nothing
	task automatic test_store_reuse();
		wait_idle();
		send_request(mk(kmct_pkg::ACT_CLEAR));
		for (int v = 0; v < 3; v++) load_vector(0, 1);
		repeat (5) send_request(mk(kmct_pkg::ACT_LOAD, 16'h1234));
		send_request(mk(kmct_pkg::ACT_SEED, 0, 12'd2, 3'd6));
		send_request(mk(kmct_pkg::ACT_SEED, 0, 12'd3, 3'd5));
		for (int k = 0; k < NDIM; k++)
			send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd6, 4'(k)));
		send_request(mk(kmct_pkg::ACT_CLEAR));
		send_request(mk(kmct_pkg::ACT_SEED, 0, 12'd0, 3'd4));
		send_request(mk(kmct_pkg::ACT_RUN));
		send_request(mk(kmct_pkg::ACT_READ, 0, 0, 3'd4, 4'd3));
	endtask

	initial begin
		mismatches = 0;
		burst_left = 0;
		valid_high = 1'b0;
		hold_request = 0;
		random_items = 0;
		stored_vectors = 0;
		fill_pos = 0;
		last_dist = 0;
		iter_limit = 100;
		conv_threshold = 1;
		foreach (vec_mem[i]) vec_mem[i] = 0;
		foreach (codebook[i]) codebook[i] = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.action <= kmct_pkg::ACT_LOAD;
		req_ch.coefficient <= '0;
		req_ch.vector_index <= '0;
		req_ch.centroid_index <= '0;
		req_ch.coefficient_index <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_data();
		test_directed();
		test_register_extremes();
		test_empty_cluster();
		test_backpressure();
		test_random_sessions();
		test_store_reuse();
		wait_idle();

		if (mismatches == 0 && awaited_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

// ----- kmeans_codebook_trainer.f -----
hdl/kmct_pkg.sv
hdl/kmct_if.sv
hdl/kmct_ram.sv
hdl/kmct_div.sv
hdl/kmeans_codebook_trainer.sv
hdl/kmct_checker.sv
dv/testbench.sv
